FILE: src/kcs_pkg.sv
// Package for the Khmer cluster shaper: categories, glyph constants, cell and
// handshake structs, sequencer states and the code point category lookup.
// No dependencies.
package kcs_pkg;

    localparam int SLOTS_DEFAULT = 10;

    typedef enum logic [3:0] {
        CLS_PRE_VOWEL  = 4'd0,
        CLS_SUB_RO     = 4'd1,
        CLS_CONS       = 4'd2,
        CLS_SUB        = 4'd3,
        CLS_SUB_POST   = 4'd4,
        CLS_SHIFTER    = 4'd5,
        CLS_BELOW      = 4'd6,
        CLS_ABOVE      = 4'd7,
        CLS_REPH       = 4'd8,
        CLS_POST_VOWEL = 4'd9,
        CLS_SIGN       = 4'd10,
        CLS_FINAL_SIGN = 4'd11,
        CLS_NONE       = 4'd12
    } cat_t;

    typedef struct packed {
        logic [15:0] code;
        cat_t        cat;
    } cell_t;

    localparam cell_t CELL_EMPTY = '{code: 16'h0000, cat: CLS_NONE};

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_CLEAR,
        CELL_ROT1,
        CELL_ROT2,
        CELL_SORT
    } cell_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PUSH,
        ST_PASS,
        ST_SINGLE,
        ST_PASS_A,
        ST_SORT1,
        ST_PASS_B,
        ST_PASS_C,
        ST_SORT2,
        ST_PASS_D,
        ST_EMIT,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        emit;
        logic        finish;
        logic [15:0] glyph;
        logic        ovf;
    } out_req_t;

    typedef struct packed {
        logic ready;
        logic hold_valid;
    } out_sts_t;

    // Offsets and special code points.
    localparam logic [15:0] KHMER_FIRST   = 16'h1780;
    localparam logic [15:0] KHMER_LAST    = 16'h17EB;
    localparam logic [15:0] OFS_SUB       = 16'hC880; // 0xE000 - 0x1780
    localparam logic [15:0] OFS_RO_VOWEL  = 16'hC920; // 0xE0A0 - 0x1780
    localparam logic [15:0] OFS_BA_NEXT   = 16'hC960; // 0xE0E0 - 0x1780
    localparam logic [15:0] OFS_SHIFT     = 16'h0050;
    localparam logic [15:0] CP_COENG      = 16'h17D2;
    localparam logic [15:0] CP_PRE_E      = 16'h17C1;
    localparam logic [15:0] CP_AA         = 16'h17B6;
    localparam logic [15:0] CP_RO         = 16'h179A;
    localparam logic [15:0] CP_VO         = 16'h179C;
    localparam logic [15:0] CP_BA         = 16'h1794;
    localparam logic [15:0] CP_NHO        = 16'h1789;
    localparam logic [15:0] CP_LA         = 16'h17A1;
    localparam logic [15:0] CP_NIKAHIT    = 16'h17C6;
    localparam logic [15:0] CP_MUUSIK     = 16'h17C9;
    localparam logic [15:0] CP_TRIISAP    = 16'h17CA;
    localparam logic [15:0] CP_U          = 16'h17BB;
    localparam logic [15:0] CP_I          = 16'h17B7;
    localparam logic [15:0] CP_TOANDA     = 16'h17CD;
    localparam logic [15:0] CP_OE         = 16'h17C4;
    localparam logic [15:0] CP_AU         = 16'h17C5;
    localparam logic [15:0] CP_YA_VB      = 16'h17BF;
    localparam logic [15:0] CP_IE         = 16'h17C0;
    localparam logic [15:0] CP_SA         = 16'h179F;
    localparam logic [15:0] CP_YO         = 16'h1799;
    localparam logic [15:0] CP_DA         = 16'h178D;
    localparam logic [15:0] CP_NNO        = 16'h178E;
    localparam logic [15:0] CP_LO         = 16'h179B;
    localparam logic [15:0] CP_HA         = 16'h17A0;
    localparam logic [15:0] CP_KHO        = 16'h1783;
    localparam logic [15:0] CP_NGO        = 16'h1788;
    localparam logic [15:0] GL_SUB_RO     = 16'hE01A;
    localparam logic [15:0] GL_SUB_KHO    = 16'hE003;
    localparam logic [15:0] GL_SUB_NGO    = 16'hE008;
    localparam logic [15:0] GL_SUB_YO     = 16'hE019;
    localparam logic [15:0] GL_SUB_NHO    = 16'hE009;
    localparam logic [15:0] GL_NHO_LIG    = 16'hE059;
    localparam logic [15:0] GL_I_TOANDA   = 16'hE030;
    localparam logic [15:0] GL_BA_AA      = 16'h17EA;
    localparam logic [15:0] GL_NHO_SUB    = 16'h17EB;

    function automatic cat_t cat_of(input logic [15:0] c);
        cat_t r;
        if (c < KHMER_FIRST || c > KHMER_LAST) r = CLS_NONE;
        else if (c <= 16'h17A2) r = CLS_CONS;
        else if (c <= 16'h17A4) r = CLS_NONE;
        else if (c <= 16'h17B3) r = CLS_CONS;
        else if (c <= 16'h17B5) r = CLS_NONE;
        else if (c == 16'h17B6) r = CLS_POST_VOWEL;
        else if (c <= 16'h17BA) r = CLS_ABOVE;
        else if (c <= 16'h17BD) r = CLS_BELOW;
        else if (c <= 16'h17C0) r = CLS_POST_VOWEL;
        else if (c <= 16'h17C3) r = CLS_PRE_VOWEL;
        else if (c <= 16'h17C5) r = CLS_POST_VOWEL;
        else if (c == 16'h17C6) r = CLS_SIGN;
        else if (c <= 16'h17C8) r = CLS_FINAL_SIGN;
        else if (c <= 16'h17CA) r = CLS_SHIFTER;
        else if (c == 16'h17CB) r = CLS_SIGN;
        else if (c == 16'h17CC) r = CLS_REPH;
        else if (c <= 16'h17D1) r = CLS_SIGN;
        else if (c == 16'h17D2) r = CLS_SUB;
        else if (c == 16'h17D3) r = CLS_SIGN;
        else if (c <= 16'h17DC) r = CLS_NONE;
        else if (c == 16'h17DD) r = CLS_SIGN;
        else if (c <= 16'h17DF) r = CLS_PRE_VOWEL;
        else r = CLS_NONE;
        return r;
    endfunction

endpackage

FILE: src/kcs_cell.sv
// One slot of the cluster row: holds a code and its category.
// Depends on kcs_pkg.
module kcs_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  kcs_pkg::cell_op_t op,
    input  logic              lead,
    input  logic              follow,
    input  kcs_pkg::cell_t    left_q,
    input  kcs_pkg::cell_t    right_q,
    input  kcs_pkg::cell_t    in1,
    input  kcs_pkg::cell_t    in2,
    input  kcs_pkg::cell_t    ld,
    output kcs_pkg::cell_t    q
);
    import kcs_pkg::*;

    cell_t q_reg, q_next;

    // In a sort round the cell either leads a pair with its right neighbor or
    // follows its left one; a swap happens only on a strictly larger category,
    // which keeps the order stable.
    always_comb begin
        q_next = q_reg;
        unique case (op)
            CELL_HOLD:  q_next = q_reg;
            CELL_LOAD:  q_next = ld;
            CELL_CLEAR: q_next = CELL_EMPTY;
            CELL_ROT1:  q_next = in1;
            CELL_ROT2:  q_next = in2;
            CELL_SORT: begin
                if (lead && (q_reg.cat > right_q.cat)) q_next = right_q;
                else if (follow && (left_q.cat > q_reg.cat)) q_next = left_q;
            end
            default:    q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= CELL_EMPTY;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/kcs_out_stage.sv
// Output stage: one glyph held back so the last one of a step can be marked,
// followed by the output register.
// Depends on kcs_pkg.
module kcs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  kcs_pkg::out_req_t req,
    output kcs_pkg::out_sts_t sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);
    import kcs_pkg::*;

    logic        hold_v_reg, hold_v_next;
    logic [15:0] hold_g_reg, hold_g_next;
    logic        hold_o_reg, hold_o_next;
    logic        mv_reg, mv_next;
    logic [15:0] mg_reg, mg_next;
    logic        ml_reg, ml_next;
    logic        mo_reg, mo_next;
    logic        ready;

    assign ready = !hold_v_reg || !mv_reg || m_tready;

    always_comb begin
        hold_v_next = hold_v_reg;
        hold_g_next = hold_g_reg;
        hold_o_next = hold_o_reg;
        mg_next     = mg_reg;
        ml_next     = ml_reg;
        mo_next     = mo_reg;
        mv_next     = mv_reg && !m_tready;
        if (req.emit && ready) begin
            if (hold_v_reg) begin
                mv_next = 1'b1;
                mg_next = hold_g_reg;
                mo_next = hold_o_reg;
                ml_next = 1'b0;
            end
            hold_v_next = 1'b1;
            hold_g_next = req.glyph;
            hold_o_next = req.ovf;
        end else if (req.finish && ready && hold_v_reg) begin
            mv_next     = 1'b1;
            mg_next     = hold_g_reg;
            mo_next     = hold_o_reg;
            ml_next     = 1'b1;
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            hold_v_reg <= hold_v_next;
            mv_reg     <= mv_next;
        end
        hold_g_reg <= hold_g_next;
        hold_o_reg <= hold_o_next;
        mg_reg     <= mg_next;
        ml_reg     <= ml_next;
        mo_reg     <= mo_next;
    end

    assign sts.ready      = ready;
    assign sts.hold_valid = hold_v_reg;
    assign m_tvalid       = mv_reg;
    assign m_tdata        = mg_reg;
    assign m_tlast        = ml_reg;
    assign m_tuser        = mo_reg;

endmodule

FILE: src/khmer_cluster_shaper_core.sv
// Top level of the Khmer cluster shaper: sequencer, row of slot cells and
// output stage. Depends on kcs_pkg, kcs_cell and kcs_out_stage.
//
//  Channel  Direction  Words carried
//  s_       in         one code point per word, tlast ends the text
//  m_       out        one glyph per word, tlast ends the glyphs of one input word
//
// One input word is taken at a time. A word that closes a cluster of two or
// more codes then goes through a sweep of the cell row for each of three
// shaping passes, a class pass over the whole row at once, two sorts of the
// row by category, and a sweep to emit. Reset clears the cluster row, the
// counters and the valid flags of both output registers at once.
// A stalled m_ side holds the sweep until the output frees.
module khmer_cluster_shaper_core #(
    parameter int CLUSTER_SLOTS = kcs_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_point
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] glyph_code
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser    // [0] overflow
);
    import kcs_pkg::*;

    localparam int IW = $clog2(CLUSTER_SLOTS + 1);
    localparam logic [IW-1:0] LAST_I  = IW'(CLUSTER_SLOTS - 1);
    localparam logic [IW-1:0] SLOTS_I = IW'(CLUSTER_SLOTS);
    localparam logic [IW:0]   SLOTS_X = (IW + 1)'(CLUSTER_SLOTS);

    state_t      state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic        eot_reg, eot_next;
    cat_t        cat_reg, cat_next;
    logic        prev_coeng_reg, prev_coeng_next;
    logic        uv_reg, uv_next;
    logic        drop_reg, drop_next;
    logic        eot_phase_reg, eot_phase_next;   // 1: flush at end of text
    logic        coeng_reg, coeng_next;
    logic        cpost_reg, cpost_next;
    logic        aa_reg, aa_next;

    cell_t    cq   [CLUSTER_SLOTS];
    cell_t    mods [CLUSTER_SLOTS];
    cell_t    ldv  [CLUSTER_SLOTS];
    cell_op_t cop  [CLUSTER_SLOTS];

    out_req_t req;
    out_sts_t sts;

    // Window signals around the slot at the head of the row.
    cell_t        cur, n1, n2, p1, p2;
    logic         p1v, p2v, n1v, n2v;
    logic [15:0]  e, ne1, ne2, p1c, p2c, n1c;
    cat_t         k, nk1;
    logic         skip, do_flush, ins;
    logic [IW:0]  i_sum, push_sum;

    assign cur = cq[0];
    assign n1  = cq[1];
    assign n2  = cq[2];
    assign p1  = cq[CLUSTER_SLOTS-1];
    assign p2  = cq[CLUSTER_SLOTS-2];
    assign p1v = (i_reg != '0);
    assign p2v = (i_reg >= IW'(2));
    assign n1v = (i_reg < LAST_I);
    assign n2v = (i_reg < IW'(CLUSTER_SLOTS - 2));
    assign p1c = p1v ? p1.code : 16'h0000;
    assign p2c = p2v ? p2.code : 16'h0000;
    assign n1c = n1v ? n1.code : 16'h0000;
    assign ins = (cnt_reg != '0) && (cat_reg == CLS_POST_VOWEL) && (cp_reg != CP_AA);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            cnt_reg        <= '0;
            prev_coeng_reg <= 1'b0;
            uv_reg         <= 1'b0;
            drop_reg       <= 1'b0;
            eot_phase_reg  <= 1'b0;
            coeng_reg      <= 1'b0;
            cpost_reg      <= 1'b0;
            aa_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            cnt_reg        <= cnt_next;
            prev_coeng_reg <= prev_coeng_next;
            uv_reg         <= uv_next;
            drop_reg       <= drop_next;
            eot_phase_reg  <= eot_phase_next;
            coeng_reg      <= coeng_next;
            cpost_reg      <= cpost_next;
            aa_reg         <= aa_next;
        end
        cp_reg  <= cp_next;
        eot_reg <= eot_next;
        cat_reg <= cat_next;
    end

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        cnt_next        = cnt_reg;
        cp_next         = cp_reg;
        eot_next        = eot_reg;
        cat_next        = cat_reg;
        prev_coeng_next = prev_coeng_reg;
        uv_next         = uv_reg;
        drop_next       = drop_reg;
        eot_phase_next  = eot_phase_reg;
        coeng_next      = coeng_reg;
        cpost_next      = cpost_reg;
        aa_next         = aa_reg;
        req             = '0;
        do_flush        = 1'b0;
        skip            = 1'b0;
        e               = cur.code;
        k               = cur.cat;
        ne1             = n1.code;
        nk1             = n1.cat;
        ne2             = n2.code;
        i_sum           = {1'b0, i_reg} + (IW + 1)'(1);
        push_sum        = {1'b0, cnt_reg} + (ins ? (IW + 1)'(2) : (IW + 1)'(1));
        for (int j = 0; j < CLUSTER_SLOTS; j++) begin
            mods[j] = cq[j];
            ldv[j]  = cq[j];
            cop[j]  = CELL_HOLD;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cp_next    = s_tdata;
                    eot_next   = s_tlast;
                    cat_next   = cat_of(s_tdata);
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                eot_phase_next = 1'b0;
                if (cat_reg == CLS_NONE) begin
                    if (cnt_reg != '0) do_flush = 1'b1;
                    else state_next = ST_PASS;
                end else if ((cnt_reg != '0) && !prev_coeng_reg && (cat_reg == CLS_CONS)) begin
                    do_flush = 1'b1;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // Past the first code a post vowel but AA adds its pre-vowel half.
                for (int j = 0; j < CLUSTER_SLOTS; j++) begin
                    if (IW'(j) == cnt_reg) begin
                        cop[j] = CELL_LOAD;
                        ldv[j] = '{code: ins ? CP_PRE_E : cp_reg, cat: CLS_NONE};
                    end else if (ins && ((IW + 1)'(j) == ({1'b0, cnt_reg} + (IW + 1)'(1)))) begin
                        cop[j] = CELL_LOAD;
                        ldv[j] = '{code: cp_reg, cat: CLS_NONE};
                    end
                end
                if (push_sum > SLOTS_X) begin
                    cnt_next  = SLOTS_I;
                    drop_next = 1'b1;
                end else begin
                    cnt_next = push_sum[IW-1:0];
                end
                if ((cnt_reg != '0) && ((cp_reg == CP_NIKAHIT) || (cat_reg == CLS_ABOVE)))
                    uv_next = 1'b1;
                prev_coeng_next = (cat_reg == CLS_SUB);
                if (eot_reg) begin
                    eot_phase_next = 1'b1;
                    do_flush       = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PASS: begin
                req.emit  = 1'b1;
                req.glyph = cp_reg;
                req.ovf   = 1'b0;
                if (sts.ready) state_next = ST_FINISH;
            end
            ST_SINGLE: begin
                req.emit  = 1'b1;
                req.glyph = cur.code;
                req.ovf   = drop_reg;
                if (sts.ready) state_next = ST_CLEAR;
            end
            ST_PASS_A: begin
                // Categories, and a coeng folds into the subscript form of the
                // following letter.
                k = CLS_NONE;
                if (e != 16'h0000) begin
                    k = cat_of(e);
                    if (p1v && (p1.code == CP_COENG)) begin
                        if (e != CP_RO) coeng_next = 1'b1;
                        e = e + OFS_SUB;
                        k = CLS_SUB;
                        mods[CLUSTER_SLOTS-1] = CELL_EMPTY;
                    end
                    if ((e == CP_NHO) || (e == CP_LA)) coeng_next = 1'b1;
                end
                mods[0] = '{code: e, cat: k};
                for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = CELL_ROT1;
                i_next = i_sum[IW-1:0];
                if (i_reg == LAST_I) begin
                    i_next     = '0;
                    state_next = ST_SORT1;
                end
            end
            ST_SORT1, ST_SORT2: begin
                for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = CELL_SORT;
                i_next = i_sum[IW-1:0];
                if (i_reg == LAST_I) begin
                    i_next     = '0;
                    state_next = (state_reg == ST_SORT1) ? ST_PASS_B : ST_PASS_D;
                end
            end
            ST_PASS_B: begin
                // Subscript RO and the post subscripts get their own classes.
                for (int j = 1; j < CLUSTER_SLOTS; j++) begin
                    cop[j] = CELL_LOAD;
                    if (cq[j].code == GL_SUB_RO) ldv[j].cat = CLS_SUB_RO;
                    if ((cq[j].code == GL_SUB_KHO) || (cq[j].code == GL_SUB_NGO) ||
                        (cq[j].code == GL_SUB_YO)) begin
                        ldv[j].cat = CLS_SUB_POST;
                        cpost_next = 1'b1;
                    end
                    if ((cq[j].code == CP_AA) || (cq[j].code == CP_OE) || (cq[j].code == CP_AU))
                        aa_next = 1'b1;
                end
                i_next     = '0;
                state_next = ST_PASS_C;
            end
            ST_PASS_C: begin
                // RO, TREYSAP and shifter features.
                if (e != 16'h0000) begin
                    if ((k == CLS_SUB_RO) && coeng_reg && !cpost_reg &&
                        (p2c != CP_SA) && (p2c != CP_YO) && (p1c != CP_DA) &&
                        (p1c != CP_NNO) && (p2c != CP_LO) && (p2c != CP_HA) &&
                        (p1c != CP_KHO) && (p1c != CP_NGO) && (p2c != CP_NHO))
                        e = e + OFS_SHIFT;
                    if ((k == CLS_SUB_POST) && p1v && (p1.cat == CLS_SUB))
                        e = e + OFS_SHIFT;
                    if (((e == CP_RO) || (e == CP_VO)) && n1v) begin
                        if ((n1.cat == CLS_ABOVE) || (ne1 == CP_NIKAHIT) || (ne1 == CP_MUUSIK))
                            ne1 = ne1 + OFS_RO_VOWEL;
                    end
                    if ((e == CP_BA) && (n1c == CP_TRIISAP)) begin
                        skip = 1'b1;
                        if (n2v && (ne2 != 16'h0000)) ne2 = ne2 + OFS_BA_NEXT;
                    end else if (((e == CP_MUUSIK) || (e == CP_TRIISAP)) && uv_reg) begin
                        e = CP_U;
                        k = CLS_BELOW;
                    end
                end
                mods[0] = '{code: e, cat: k};
                mods[1] = '{code: ne1, cat: n1.cat};
                mods[2] = '{code: ne2, cat: n2.cat};
                for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = skip ? CELL_ROT2 : CELL_ROT1;
                if (skip) i_sum = {1'b0, i_reg} + (IW + 1)'(2);
                i_next = i_sum[IW-1:0];
                if (i_sum >= SLOTS_X) begin
                    i_next     = '0;
                    state_next = ST_SORT2;
                end
            end
            ST_PASS_D: begin
                // Vowel, BA and NHO ligatures, subscript vowel forms.
                if (e != 16'h0000) begin
                    if ((e == CP_I) && (n1c == CP_TOANDA)) begin
                        e   = GL_I_TOANDA;
                        ne1 = 16'h0000;
                        nk1 = CLS_NONE;
                    end
                    if ((e == CP_BA) && aa_reg && !cpost_reg) e = GL_BA_AA;
                    if (e == CP_NHO) begin
                        if (n1v && ((nk1 == CLS_SUB) || (nk1 == CLS_SUB_POST)))
                            e = GL_NHO_SUB;
                        if (n1v && (ne1 == GL_SUB_NHO)) ne1 = GL_NHO_LIG;
                    end
                    if ((k == CLS_POST_VOWEL) && coeng_reg && ((e == CP_YA_VB) || (e == CP_IE)))
                        e = e + OFS_SUB;
                    if ((k == CLS_BELOW) && coeng_reg) e = e + OFS_SUB;
                end
                mods[0] = '{code: e, cat: k};
                mods[1] = '{code: ne1, cat: nk1};
                for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = CELL_ROT1;
                i_next = i_sum[IW-1:0];
                if (i_reg == LAST_I) begin
                    i_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                req.emit  = (cur.code != 16'h0000);
                req.glyph = cur.code;
                req.ovf   = drop_reg;
                if ((cur.code == 16'h0000) || sts.ready) begin
                    for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = CELL_ROT1;
                    i_next = i_sum[IW-1:0];
                    if (i_reg == LAST_I) begin
                        i_next     = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                for (int j = 0; j < CLUSTER_SLOTS; j++) cop[j] = CELL_CLEAR;
                cnt_next        = '0;
                prev_coeng_next = 1'b0;
                uv_next         = 1'b0;
                drop_next       = 1'b0;
                if (eot_phase_reg) state_next = ST_FINISH;
                else if (cat_reg == CLS_NONE) state_next = ST_PASS;
                else state_next = ST_PUSH;
            end
            ST_FINISH: begin
                req.finish = 1'b1;
                if (sts.ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // The count seen here includes a code pushed in this same cycle.
        if (do_flush) begin
            i_next     = '0;
            coeng_next = 1'b0;
            cpost_next = 1'b0;
            aa_next    = 1'b0;
            if (cnt_next == '0) state_next = ST_CLEAR;
            else if (cnt_next == IW'(1)) state_next = ST_SINGLE;
            else state_next = ST_PASS_A;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    for (genvar j = 0; j < CLUSTER_SLOTS; j++) begin : g_cell
        cell_t left_w, right_w;
        logic  lead_w, follow_w;
        if (j == 0) begin : g_first
            assign left_w   = CELL_EMPTY;
            assign follow_w = 1'b0;
        end else begin : g_mid
            assign left_w   = cq[j-1];
            assign follow_w = (i_reg[0] == 1'((j - 1) % 2));
        end
        if (j == CLUSTER_SLOTS - 1) begin : g_last
            assign right_w = CELL_EMPTY;
            assign lead_w  = 1'b0;
        end else begin : g_body
            assign right_w = cq[j+1];
            assign lead_w  = (i_reg[0] == 1'(j % 2));
        end
        kcs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (cop[j]),
            .lead    (lead_w),
            .follow  (follow_w),
            .left_q  (left_w),
            .right_q (right_w),
            .in1     (mods[(j + 1) % CLUSTER_SLOTS]),
            .in2     (mods[(j + 2) % CLUSTER_SLOTS]),
            .ld      (ldv[j]),
            .q       (cq[j])
        );
    end

    kcs_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Every glyph of the previous word has left the hold stage when a new
    // word may enter.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.hold_valid)
        else $error("glyph still held while idle");

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECIDE))
        else $error("accepted word not decoded");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SLOTS_I)
        else $error("cluster count beyond slots");

    a_pass_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PASS_B) |=> (state_reg == ST_PASS_C))
        else $error("shaping passes out of order");

endmodule

FILE: dv/tb.sv
// Testbench for khmer_cluster_shaper_core: drives code points with random gaps,
// predicts glyph words with a behavioral shaper and checks them in a scoreboard.
// Depends on kcs_pkg and the shaper RTL.
`timescale 1ns / 100ps

class glyph_scoreboard;
    localparam int SLOTS = 10;
    logic [15:0] codes[SLOTS];
    int unsigned count;
    kcs_pkg::cat_t prev_cat;
    bit upper_seen;
    bit dropped;
    logic [17:0] pending[$];   // {overflow, last, glyph}
    int unsigned errors;

    function new();
        for (int i = 0; i < SLOTS; i++) codes[i] = '0;
        count = 0;
        prev_cat = kcs_pkg::CLS_NONE;
        upper_seen = 0;
        dropped = 0;
        errors = 0;
    endfunction

    // Slot category as the shaper assigns it: empty slots read as other.
    function automatic kcs_pkg::cat_t cat_code(logic [15:0] c);
        kcs_pkg::cat_t r;
        if (c < 16'h1780 || c > 16'h17EB) r = kcs_pkg::CLS_NONE;
        else if (c <= 16'h17A2) r = kcs_pkg::CLS_CONS;
        else if (c <= 16'h17A4) r = kcs_pkg::CLS_NONE;
        else if (c <= 16'h17B3) r = kcs_pkg::CLS_CONS;
        else if (c <= 16'h17B5) r = kcs_pkg::CLS_NONE;
        else if (c == 16'h17B6) r = kcs_pkg::CLS_POST_VOWEL;
        else if (c <= 16'h17BA) r = kcs_pkg::CLS_ABOVE;
        else if (c <= 16'h17BD) r = kcs_pkg::CLS_BELOW;
        else if (c <= 16'h17C0) r = kcs_pkg::CLS_POST_VOWEL;
        else if (c <= 16'h17C3) r = kcs_pkg::CLS_PRE_VOWEL;
        else if (c <= 16'h17C5) r = kcs_pkg::CLS_POST_VOWEL;
        else if (c == 16'h17C6) r = kcs_pkg::CLS_SIGN;
        else if (c <= 16'h17C8) r = kcs_pkg::CLS_FINAL_SIGN;
        else if (c <= 16'h17CA) r = kcs_pkg::CLS_SHIFTER;
        else if (c == 16'h17CB) r = kcs_pkg::CLS_SIGN;
        else if (c == 16'h17CC) r = kcs_pkg::CLS_REPH;
        else if (c <= 16'h17D1) r = kcs_pkg::CLS_SIGN;
        else if (c == 16'h17D2) r = kcs_pkg::CLS_SUB;
        else if (c == 16'h17D3) r = kcs_pkg::CLS_SIGN;
        else if (c <= 16'h17DC) r = kcs_pkg::CLS_NONE;
        else if (c == 16'h17DD) r = kcs_pkg::CLS_SIGN;
        else if (c <= 16'h17DF) r = kcs_pkg::CLS_PRE_VOWEL;
        else r = kcs_pkg::CLS_NONE;
        return r;
    endfunction

    function automatic void sort_slots(ref logic [15:0] e[SLOTS], ref kcs_pkg::cat_t k[SLOTS]);
        logic [15:0] ve;
        kcs_pkg::cat_t vk;
        int j;
        for (int i = 1; i < SLOTS; i++) begin
            ve = e[i];
            vk = k[i];
            j = i;
            while (j > 0 && k[j-1] > vk) begin
                e[j] = e[j-1];
                k[j] = k[j-1];
                j--;
            end
            e[j] = ve;
            k[j] = vk;
        end
    endfunction

    function automatic logic [15:0] code_at(ref logic [15:0] e[SLOTS], input int i);
        return (i >= 0 && i < SLOTS) ? e[i] : 16'h0;
    endfunction

    function automatic kcs_pkg::cat_t cat_at(ref kcs_pkg::cat_t k[SLOTS], input int i);
        return (i >= 0 && i < SLOTS) ? k[i] : kcs_pkg::CLS_NONE;
    endfunction

    function automatic void shape(ref logic [17:0] outq[$]);
        logic [15:0] e[SLOTS];
        kcs_pkg::cat_t k[SLOTS];
        bit coeng, cpost, aa;
        logic [15:0] p1, p2;
        kcs_pkg::cat_t nk;
        int i;
        coeng = 0; cpost = 0; aa = 0;
        for (i = 0; i < SLOTS; i++) e[i] = codes[i];
        for (i = 0; i < SLOTS; i++) begin
            k[i] = kcs_pkg::CLS_NONE;
            if (e[i] != 0) begin
                k[i] = cat_code(e[i]);
                if (i > 0 && e[i-1] == 16'h17D2) begin
                    if (e[i] != 16'h179A) coeng = 1;
                    e[i] = e[i] + 16'hC880;
                    k[i] = kcs_pkg::CLS_SUB;
                    e[i-1] = 0;
                    k[i-1] = kcs_pkg::CLS_NONE;
                end
                if (e[i] == 16'h1789 || e[i] == 16'h17A1) coeng = 1;
            end
        end
        sort_slots(e, k);
        for (i = 1; i < SLOTS; i++) begin
            if (e[i] == 16'hE01A) k[i] = kcs_pkg::CLS_SUB_RO;
            if (e[i] == 16'hE003 || e[i] == 16'hE008 || e[i] == 16'hE019) begin
                k[i] = kcs_pkg::CLS_SUB_POST;
                cpost = 1;
            end
            if (e[i] == 16'h17B6 || e[i] == 16'h17C4 || e[i] == 16'h17C5) aa = 1;
        end
        i = 0;
        while (i < SLOTS) begin
            if (e[i] != 0) begin
                if (k[i] == kcs_pkg::CLS_SUB_RO && coeng && !cpost) begin
                    p2 = code_at(e, i - 2);
                    p1 = code_at(e, i - 1);
                    if (p2 != 16'h179F && p2 != 16'h1799 && p1 != 16'h178D && p1 != 16'h178E &&
                        p2 != 16'h179B && p2 != 16'h17A0 && p1 != 16'h1783 && p1 != 16'h1788 &&
                        p2 != 16'h1789)
                        e[i] = e[i] + 16'h0050;
                end
                if (k[i] == kcs_pkg::CLS_SUB_POST && cat_at(k, i - 1) == kcs_pkg::CLS_SUB)
                    e[i] = e[i] + 16'h0050;
                if ((e[i] == 16'h179A || e[i] == 16'h179C) && i + 1 < SLOTS) begin
                    if (k[i+1] == kcs_pkg::CLS_ABOVE || e[i+1] == 16'h17C6 || e[i+1] == 16'h17C9)
                        e[i+1] = e[i+1] + 16'hC920;
                end
                if (e[i] == 16'h1794 && code_at(e, i + 1) == 16'h17CA) begin
                    i++;
                    if (i + 1 < SLOTS && e[i+1] != 0) e[i+1] = e[i+1] + 16'hC960;
                end else if (e[i] == 16'h17C9 || e[i] == 16'h17CA) begin
                    if (upper_seen) begin
                        e[i] = 16'h17BB;
                        k[i] = kcs_pkg::CLS_BELOW;
                    end
                end
            end
            i++;
        end
        sort_slots(e, k);
        for (i = 0; i < SLOTS; i++) begin
            if (e[i] != 0) begin
                if (e[i] == 16'h17B7 && code_at(e, i + 1) == 16'h17CD) begin
                    e[i] = 16'hE030;
                    e[i+1] = 0;
                    k[i+1] = kcs_pkg::CLS_NONE;
                end
                if (e[i] == 16'h1794 && aa && !cpost) e[i] = 16'h17EA;
                if (e[i] == 16'h1789) begin
                    nk = cat_at(k, i + 1);
                    if (nk == kcs_pkg::CLS_SUB || nk == kcs_pkg::CLS_SUB_POST)
                        e[i] = 16'h17EB;
                    if (code_at(e, i + 1) == 16'hE009) e[i+1] = 16'hE059;
                end
                if (k[i] == kcs_pkg::CLS_POST_VOWEL && coeng &&
                    (e[i] == 16'h17BF || e[i] == 16'h17C0))
                    e[i] = e[i] + 16'hC880;
                if (k[i] == kcs_pkg::CLS_BELOW && coeng) e[i] = e[i] + 16'hC880;
            end
        end
        for (i = 0; i < SLOTS; i++)
            if (e[i] != 0) outq.push_back({dropped, 1'b0, e[i]});
    endfunction

    function automatic void close_cluster(ref logic [17:0] outq[$]);
        if (count == 1) outq.push_back({dropped, 1'b0, codes[0]});
        else if (count > 1) shape(outq);
        for (int i = 0; i < SLOTS; i++) codes[i] = '0;
        count = 0;
        prev_cat = kcs_pkg::CLS_NONE;
        upper_seen = 0;
        dropped = 0;
    endfunction

    function automatic void store(logic [15:0] c);
        if (count < SLOTS) begin
            codes[count] = c;
            count++;
        end else begin
            dropped = 1;
        end
    endfunction

    // Notes one accepted code point and queues the glyph words it causes.
    function void note_code(logic [15:0] cp, bit eot);
        logic [17:0] outq[$];
        kcs_pkg::cat_t c;
        c = cat_code(cp);
        if (c == kcs_pkg::CLS_NONE) begin
            close_cluster(outq);
            outq.push_back({1'b0, 1'b0, cp});
        end else begin
            if (count > 0 && prev_cat != kcs_pkg::CLS_SUB && c == kcs_pkg::CLS_CONS)
                close_cluster(outq);
            if (count > 0) begin
                if (c == kcs_pkg::CLS_POST_VOWEL && cp != 16'h17B6) store(16'h17C1);
                if (cp == 16'h17C6 || c == kcs_pkg::CLS_ABOVE) upper_seen = 1;
            end
            store(cp);
            prev_cat = c;
        end
        if (eot) close_cluster(outq);
        if (outq.size() > 0) outq[outq.size()-1][16] = 1'b1;
        foreach (outq[n]) pending.push_back(outq[n]);
    endfunction

    // Checks one accepted glyph word against the oldest expectation.
    function void check_glyph(logic [15:0] g, logic last, logic ovf);
        logic [17:0] x;
        if (pending.size() == 0) begin
            $error("glyph_code expected none actual %h", g);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (g !== x[15:0]) begin
            $error("glyph_code expected %h actual %h", x[15:0], g);
            errors++;
        end
        if (last !== x[16]) begin
            $error("run_last expected %b actual %b", x[16], last);
            errors++;
        end
        if (ovf !== x[17]) begin
            $error("overflow expected %b actual %b", x[17], ovf);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    glyph_scoreboard board = new();
    bit hold_sink = 0;
    int unsigned idle_cycles = 0;
    int unsigned sent_count = 0;

    // Khmer letters used by the shaping features, plus common vowels and signs.
    logic [15:0] khmer_pool[] = '{16'h1780, 16'h1783, 16'h1788, 16'h1789, 16'h178D,
        16'h178E, 16'h1794, 16'h1799, 16'h179A, 16'h179B, 16'h179C, 16'h179F,
        16'h17A0, 16'h17A1, 16'h17A2, 16'h17B3, 16'h17B6, 16'h17B7, 16'h17BB,
        16'h17BF, 16'h17C0, 16'h17C1, 16'h17C4, 16'h17C5, 16'h17C6, 16'h17C9,
        16'h17CA, 16'h17CC, 16'h17CD, 16'h17D2, 16'h17DE, 16'h17DF};

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    khmer_cluster_shaper_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Offers one code point and holds it until the block takes it.
    task automatic send_code(logic [15:0] cp, logic eot, bit with_gap);
        int unsigned g;
        g = with_gap ? gap_len() : 0;
        repeat (g) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= cp;
        s_tlast <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_code(cp, eot);
        sent_count++;
    endtask

    task automatic idle_line();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    // Sends one cluster: a base, then signs, subscripts and vowels of random kinds.
    task automatic send_cluster(int unsigned n, bit with_gap);
        send_code(khmer_pool[$urandom_range(0, 14)], 0, with_gap);
        for (int unsigned i = 1; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_code(16'h17D2, 0, with_gap);
                send_code(khmer_pool[$urandom_range(0, 14)], 0, with_gap);
                i++;
            end else begin
                send_code(khmer_pool[$urandom_range(15, khmer_pool.size() - 1)], 0, with_gap);
            end
        end
    endtask

    // Sink side: random stalls, and one long hold when the sender asks for it.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_sink = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                repeat (gap_len() + 1) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_glyph(m_tdata, m_tlast, m_tuser[0]);
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
    end

    // Watchdog: a correct run never stays quiet this long, even with the long hold.
    always @(posedge aclk) begin
        if (idle_cycles > 5000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [15:0] cp;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: field extremes, passthrough, features and full clusters.
        send_code(16'h0000, 0, 0);
        send_code(16'hFFFF, 1, 0);
        send_code(16'h1780, 1, 0);                 // single-code cluster
        send_code(16'h17EB, 0, 0);
        send_code(16'h177F, 0, 0);
        send_code(16'h17EC, 0, 0);
        send_code(16'h17DE, 0, 0);                 // unassigned gap is a pre-vowel
        send_code(16'h1789, 0, 0);
        send_code(16'h17D2, 0, 0);
        send_code(16'h179A, 0, 0);
        send_code(16'h17BF, 0, 0);                 // inserted pre-vowel
        send_code(16'h1794, 0, 0);
        send_code(16'h17CA, 0, 0);
        send_code(16'h17B7, 0, 0);
        send_code(16'h17CD, 1, 0);
        // Overflow: more signs than slots.
        send_code(16'h1794, 0, 0);
        for (int i = 0; i < 10; i++) send_code(16'h17C4, 0, 0);
        send_code(16'h0041, 1, 0);

        // Sender pause until every expected glyph is out.
        idle_line();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        // Long sink hold while the sender keeps offering.
        hold_sink = 1;
        for (int i = 0; i < 4; i++) send_cluster(4, 0);

        // Random part: mostly well-formed clusters, some noise.
        while (sent_count < 329) begin
            case ($urandom_range(0, 9))
                0: begin
                    cp = 16'($urandom());
                    send_code(cp, 1'($urandom_range(0, 1)), 1);
                end
                1: begin
                    cp = 16'(16'h1780 + $urandom_range(0, 16'h6F));
                    send_code(cp, $urandom_range(0, 5) == 0, 1);
                end
                default: begin
                    send_cluster($urandom_range(1, 12), 1);
                    if ($urandom_range(0, 3) == 0)
                        send_code(16'h0020, 1'($urandom_range(0, 1)), 1);
                end
            endcase
        end
        send_code(16'h0020, 1, 1);
        idle_line();

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
